// ----- hw/rtl/bbum_pkg.sv -----
// Shared constants, configuration codes and stage payload types of the unsharp mask core.
package bbum_pkg;

    // Frame limits and derived index widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field widths
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int AMT_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register reset values
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = DIM_W'(480);
    localparam logic [AMT_W-1:0] SHARPEN_AMOUNT_RST = AMT_W'(192);

    // Blur: floor(sum / 9) as (sum * 7282) >> 16, exact for sums of nine bytes
    localparam int SUM_W      = 12;
    localparam int RECIP_W    = 13;
    localparam int BLUR_SHIFT = 16;
    localparam logic [RECIP_W-1:0] BLUR_RECIP = RECIP_W'(7282);

    // Sharpen arithmetic width (signed)
    localparam int V_W = 23;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_SHARPEN_AMOUNT = 2'd2
    } t_cfg_idx;

    // One new window column, front stage to emit stage
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row;
        logic             last_col;
        logic             last_row;
        logic             width_one;
    } t_col_item;

    // One result request, emit stage to sharpen stage
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] blur;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_blur_req;

endpackage

// ----- hw/rtl/box_blur_unsharp_mask_core.sv -----
// Top level of the 3x3 box-blur unsharp mask core with its configuration registers.
//
// Usage:
//  - Pixel input: i_valid / o_stall with i_pixel_in, raster order. A request is taken on a
//    clock edge with i_valid high and o_stall low.
//  - Result output: o_valid / i_stall with o_pixel_out, o_out_col, o_out_row and
//    o_last_of_step, which marks the final result caused by one input pixel.
//  - Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index selects
//    frame_width (0), frame_height (1) or sharpen_amount (2); other indexes are dropped.
//    Write only while the core is idle.
//  - Pipeline: a result is formed once the pixel that completes its window is taken and
//    passes line fetch, window/blur, gain and the output register, in that order.
//  - Throughput, while i_stall is low: one pixel per cycle. A pixel that completes 2 to 4
//    windows (row end, last row) holds the window stage until its results are sent, one
//    result per cycle; the window stage and the single line-store read port set this rate.
//  - Reset: counters, window and pipeline valids clear; registers return to 640 x 480 and
//    gain 192. The line store is not cleared; rows are written before they are read.
//  - Receiver stall: results hold in the output register, the pipeline backs up and
//    o_stall rises once every stage is full.
module box_blur_unsharp_mask_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bbum_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bbum_pkg::PIX_W-1:0]      o_pixel_out,
    output logic [bbum_pkg::COL_W-1:0]      o_out_col,
    output logic [bbum_pkg::ROW_W-1:0]      o_out_row,
    output logic                            o_last_of_step,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bbum_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbum_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bbum_pkg::*;

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [AMT_W-1:0] r_sharpen_amount;

    t_col_item        item;
    logic             take;
    t_blur_req        req;
    logic             req_ready;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= FRAME_WIDTH_RST;
            r_frame_height   <= FRAME_HEIGHT_RST;
            r_sharpen_amount <= SHARPEN_AMOUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[DIM_W-1:0];
                CFG_SHARPEN_AMOUNT: r_sharpen_amount <= i_cfg_data[AMT_W-1:0];
                default: ;
            endcase
        end
    end

    bbum_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_in     (i_pixel_in),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_take         (take),
        .o_item         (item)
    );

    bbum_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .o_take      (take),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    bbum_sharpen u_sharpen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .o_req_ready    (req_ready),
        .i_amount       (r_sharpen_amount),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_out    (o_pixel_out),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_last_of_step (o_last_of_step)
    );

    // A column with more results to send keeps the window: the next column must wait
    a_window_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.valid && !req.last) |-> !take)
        else $error("window stage took a new column with results pending");

    // An accepted pixel lands in the fetch stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> item.valid)
        else $error("accepted pixel missing from fetch stage");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// ----- hw/rtl/bbum_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bbum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/bbum_front.sv -----
// Input stage: frame counters, two-line store and column fetch with write bypass.
module bbum_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bbum_pkg::PIX_W-1:0]    i_pixel_in,
    input  logic [bbum_pkg::DIM_W-1:0]    i_frame_width,
    input  logic [bbum_pkg::DIM_W-1:0]    i_frame_height,
    input  logic                          i_take,
    output bbum_pkg::t_col_item           o_item
);
    import bbum_pkg::*;

    localparam int LINE_W = 2 * PIX_W;

    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [DIM_W-1:0]  col_next;
    logic [DIM_W-1:0]  row_next;
    logic              accept;
    logic              wr_en;
    logic [LINE_W-1:0] wr_data;
    logic [LINE_W-1:0] rd_data;
    logic [PIX_W-1:0]  upper_old;
    logic [PIX_W-1:0]  middle_old;

    logic              r_s1_valid;
    logic [COL_W-1:0]  r_col_count;
    logic [ROW_W-1:0]  r_row_count;
    logic              r_byp;
    logic [LINE_W-1:0] r_byp_data;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [COL_W-1:0]  r_s1_col;
    logic [COL_W-1:0]  r_s1_col_last;
    logic [ROW_W-1:0]  r_s1_row;
    logic              r_s1_last_col;
    logic              r_s1_last_row;
    logic              r_s1_width_one;

    // Effective frame size: zero acts as one, oversize saturates
    always_comb begin
        if (i_frame_width == '0) begin
            eff_w = DIM_W'(1);
        end else if (i_frame_width > DIM_W'(MAX_WIDTH)) begin
            eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = i_frame_width;
        end
        if (i_frame_height == '0) begin
            eff_h = DIM_W'(1);
        end else if (i_frame_height > DIM_W'(MAX_HEIGHT)) begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = i_frame_height;
        end
    end

    // Restart counters that fall outside the frame
    assign cur_col  = (DIM_W'(r_col_count) >= eff_w) ? '0 : r_col_count;
    assign cur_row  = (DIM_W'(r_row_count) >= eff_h) ? '0 : r_row_count;
    assign col_next = DIM_W'(cur_col) + DIM_W'(1);
    assign row_next = DIM_W'(cur_row) + DIM_W'(1);

    // Handshake: a request enters when the column stage is free or moving on
    assign o_stall = r_s1_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    // Line store: {upper, middle} per column, shifted down as the column leaves
    assign upper_old  = r_byp ? r_byp_data[LINE_W-1:PIX_W] : rd_data[LINE_W-1:PIX_W];
    assign middle_old = r_byp ? r_byp_data[PIX_W-1:0]      : rd_data[PIX_W-1:0];
    assign wr_en      = r_s1_valid && i_take;
    assign wr_data    = {middle_old, r_s1_pix};

    bbum_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (cur_col),
        .o_rd_data (rd_data)
    );

    // Control: stage valid, raster counters, bypass flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_col_count <= '0;
            r_row_count <= '0;
            r_byp       <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_byp      <= wr_en && (r_s1_col == cur_col);
                if (col_next >= eff_w) begin
                    r_col_count <= '0;
                    r_row_count <= (row_next >= eff_h) ? '0 : row_next[ROW_W-1:0];
                end else begin
                    r_col_count <= col_next[COL_W-1:0];
                    r_row_count <= cur_row;
                end
            end else if (i_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Payload of the accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_data     <= wr_data;
            r_s1_pix       <= i_pixel_in;
            r_s1_col       <= cur_col;
            r_s1_row       <= cur_row;
            r_s1_col_last  <= COL_W'(eff_w - DIM_W'(1));
            r_s1_last_col  <= (DIM_W'(cur_col) == eff_w - DIM_W'(1));
            r_s1_last_row  <= (DIM_W'(cur_row) == eff_h - DIM_W'(1));
            r_s1_width_one <= (eff_w == DIM_W'(1));
        end
    end

    // Column handed to the emit stage
    always_comb begin
        o_item.valid     = r_s1_valid;
        o_item.upper     = upper_old;
        o_item.middle    = middle_old;
        o_item.pix       = r_s1_pix;
        o_item.col       = r_s1_col;
        o_item.col_last  = r_s1_col_last;
        o_item.row       = r_s1_row;
        o_item.last_col  = r_s1_last_col;
        o_item.last_row  = r_s1_last_row;
        o_item.width_one = r_s1_width_one;
    end

endmodule

// ----- hw/rtl/bbum_emit.sv -----
// Emit stage: 3x3 window, result sequencing per column and box blur of each result.
module bbum_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbum_pkg::t_col_item i_item,
    output logic                o_take,
    output bbum_pkg::t_blur_req o_req,
    input  logic                i_req_ready
);
    import bbum_pkg::*;

    localparam int CS_W   = PIX_W + 2;
    localparam int PROD_W = SUM_W + RECIP_W;

    // Rows summed in one window column
    typedef enum logic [1:0] {
        RP_FULL,     // upper, middle, new
        RP_TOP_DUP,  // middle twice, new
        RP_LOW,      // middle, new twice
        RP_BOT       // new three times
    } t_rowpat;

    logic [PIX_W-1:0]  r_win [9];
    logic [3:0]        r_pend;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  r_col_last;
    logic [ROW_W-1:0]  r_row;
    logic              r_col_one;
    logic              r_width_one;

    logic [3:0]        sel;
    logic [3:0]        remain;
    logic              load;
    logic              advance;
    logic              col_b;
    logic              lower;
    t_rowpat           pat;
    logic [CS_W-1:0]   cs0;
    logic [CS_W-1:0]   cs1;
    logic [CS_W-1:0]   cs2;
    logic [CS_W-1:0]   lsum;
    logic [CS_W-1:0]   msum;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] blur_prod;
    logic [PIX_W-1:0]  src;
    logic [3:0]        new_pend;

    function automatic logic [CS_W-1:0] col_sum(input logic [PIX_W-1:0] a_up,
                                                input logic [PIX_W-1:0] a_mid,
                                                input logic [PIX_W-1:0] a_new,
                                                input t_rowpat p);
        logic [CS_W-1:0] s;
        unique case (p)
            RP_FULL:    s = CS_W'(a_up)  + CS_W'(a_mid) + CS_W'(a_new);
            RP_TOP_DUP: s = CS_W'(a_mid) + CS_W'(a_mid) + CS_W'(a_new);
            RP_LOW:     s = CS_W'(a_mid) + CS_W'(a_new) + CS_W'(a_new);
            RP_BOT:     s = CS_W'(a_new) + CS_W'(a_new) + CS_W'(a_new);
            default:    s = '0;
        endcase
        return s;
    endfunction

    // Pending results of the incoming column, in emission order
    always_comb begin
        new_pend[0] = (i_item.row != '0) && (i_item.col != '0);
        new_pend[1] = (i_item.row != '0) && i_item.last_col;
        new_pend[2] = i_item.last_row && (i_item.col != '0);
        new_pend[3] = i_item.last_row && i_item.last_col;
    end

    // Pick the oldest pending result
    assign sel     = r_pend & (~r_pend + 4'd1);
    assign remain  = r_pend & ~sel;
    assign advance = (r_pend != '0) && i_req_ready;
    assign o_take  = (r_pend == '0) || ((remain == '0) && i_req_ready);
    assign load    = i_item.valid && o_take;

    // Window selection for the chosen result
    assign col_b = sel[1] || sel[3];
    assign lower = sel[2] || sel[3];

    always_comb begin
        if (lower) begin
            pat = (r_row == '0) ? RP_BOT : RP_LOW;
        end else begin
            pat = (r_row == ROW_W'(1)) ? RP_TOP_DUP : RP_FULL;
        end
    end

    assign cs0 = col_sum(r_win[0], r_win[1], r_win[2], pat);
    assign cs1 = col_sum(r_win[3], r_win[4], r_win[5], pat);
    assign cs2 = col_sum(r_win[6], r_win[7], r_win[8], pat);

    always_comb begin
        if (col_b) begin
            lsum = r_width_one ? cs2 : cs1;
            msum = cs2;
            src  = lower ? r_win[8] : r_win[7];
        end else begin
            lsum = r_col_one ? cs1 : cs0;
            msum = cs1;
            src  = lower ? r_win[5] : r_win[4];
        end
    end

    // Blur: divide the window sum by nine through a reciprocal
    assign sum       = SUM_W'(lsum) + SUM_W'(msum) + SUM_W'(cs2);
    assign blur_prod = PROD_W'(sum) * PROD_W'(BLUR_RECIP);

    always_comb begin
        o_req.valid = r_pend != '0;
        o_req.src   = src;
        o_req.blur  = blur_prod[BLUR_SHIFT +: PIX_W];
        o_req.col   = col_b ? r_col_last : r_col - COL_W'(1);
        o_req.row   = lower ? r_row : r_row - ROW_W'(1);
        o_req.last  = remain == '0;
    end

    // Control: pending results and window contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (load) begin
                r_pend <= new_pend;
                for (int k = 0; k < 6; k++) begin
                    r_win[k] <= r_win[k+3];
                end
                r_win[6] <= i_item.upper;
                r_win[7] <= i_item.middle;
                r_win[8] <= i_item.pix;
            end else if (advance) begin
                r_pend <= remain;
            end
        end
    end

    // Position of the column now in the window
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_col       <= i_item.col;
            r_col_last  <= i_item.col_last;
            r_row       <= i_item.row;
            r_col_one   <= (i_item.col == COL_W'(1));
            r_width_one <= i_item.width_one;
        end
    end

endmodule

// ----- hw/rtl/bbum_sharpen.sv -----
// Sharpen stage: gain on the detail term, rounding, clamping and the output register.
module bbum_sharpen (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbum_pkg::t_blur_req        i_req,
    output logic                       o_req_ready,
    input  logic [bbum_pkg::AMT_W-1:0] i_amount,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bbum_pkg::PIX_W-1:0] o_pixel_out,
    output logic [bbum_pkg::COL_W-1:0] o_out_col,
    output logic [bbum_pkg::ROW_W-1:0] o_out_row,
    output logic                       o_last_of_step
);
    import bbum_pkg::*;

    localparam int DIFF_W = PIX_W + 1;
    localparam int MUL_W  = AMT_W + 1 + DIFF_W;
    localparam int Q_W    = V_W - 8;

    logic                     r_s3_valid;
    logic [PIX_W-1:0]         r_s3_src;
    logic [PIX_W-1:0]         r_s3_blur;
    logic [COL_W-1:0]         r_s3_col;
    logic [ROW_W-1:0]         r_s3_row;
    logic                     r_s3_last;
    logic                     r_out_valid;
    logic [PIX_W-1:0]         r_out_pix;
    logic [COL_W-1:0]         r_out_col;
    logic [ROW_W-1:0]         r_out_row;
    logic                     r_out_last;

    logic                     out_ready;
    logic                     s3_adv;
    logic signed [DIFF_W-1:0] diff;
    logic signed [MUL_W-1:0]  detail;
    logic signed [V_W-1:0]    v;
    logic [V_W-1:0]           v_rnd;
    logic [Q_W-1:0]           q;
    logic [PIX_W-1:0]         n_pix;

    // Stage handshake
    assign out_ready   = !r_out_valid || !i_stall;
    assign s3_adv      = r_s3_valid && out_ready;
    assign o_req_ready = !r_s3_valid || out_ready;

    // V = 256*src + amount*(src - blur), rounded half away from zero
    assign diff   = $signed({1'b0, r_s3_src}) - $signed({1'b0, r_s3_blur});
    assign detail = $signed({1'b0, i_amount}) * diff;
    assign v      = $signed({{(V_W-PIX_W-8){1'b0}}, r_s3_src, 8'h00}) + V_W'(detail);
    assign v_rnd  = v + V_W'(128);
    assign q      = v_rnd[V_W-1:8];

    // Clamp to a byte: any negative value rounds to zero or below
    always_comb begin
        if (v < 0) begin
            n_pix = '0;
        end else if (q > Q_W'(255)) begin
            n_pix = 8'hFF;
        end else begin
            n_pix = q[PIX_W-1:0];
        end
    end

    // Control: stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_s3_valid <= i_req.valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req.valid) begin
            r_s3_src  <= i_req.src;
            r_s3_blur <= i_req.blur;
            r_s3_col  <= i_req.col;
            r_s3_row  <= i_req.row;
            r_s3_last <= i_req.last;
        end
        if (s3_adv) begin
            r_out_pix  <= n_pix;
            r_out_col  <= r_s3_col;
            r_out_row  <= r_s3_row;
            r_out_last <= r_s3_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_out    = r_out_pix;
    assign o_out_col      = r_out_col;
    assign o_out_row      = r_out_row;
    assign o_last_of_step = r_out_last;

endmodule
